FILE: hdl/assert_macros.svh
// Assertion macros shared by the line generator RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
// Check a clocked property, suspended while reset is low.
`define ASSERT_AT(lbl, clk, rst_n, prop) \
  lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (prop)) \
    else $error("%m: property violated");
// Check that a condition never holds at a clock edge outside reset.
`define ASSERT_NEVER(lbl, clk, rst_n, cond) \
  lbl: assert property (@(posedge clk) disable iff (!(rst_n)) !(cond)) \
    else $error("%m: forbidden condition seen");
`else
`define ASSERT_AT(lbl, clk, rst_n, prop)
`define ASSERT_NEVER(lbl, clk, rst_n, cond)
`endif
`endif

FILE: hdl/dda_pkg.sv
// Shared types and codes of the DDA line point generator.
package dda_pkg;

  // Request command codes
  typedef enum logic {
    CMD_START   = 1'b0,
    CMD_ADVANCE = 1'b1
  } cmd_e;

  // Control from the sequencer to the shared divider
  typedef struct packed {
    logic start;
  } dda_div_req_t;

  // Status from the shared divider back to the sequencer
  typedef struct packed {
    logic busy;
    logic done;
  } dda_div_rsp_t;

endpackage

FILE: hdl/dda_if.sv
// Valid/ready channel interfaces for line requests and plotted points.
interface dda_in_if #(
  parameter int COORD_BITS = 11
);
  logic                         valid;
  logic                         ready;
  logic                         command;
  logic signed [COORD_BITS-1:0] start_x;
  logic signed [COORD_BITS-1:0] start_y;
  logic signed [COORD_BITS-1:0] end_x;
  logic signed [COORD_BITS-1:0] end_y;

  modport source (output valid, command, start_x, start_y, end_x, end_y, input ready);
  modport sink   (input valid, command, start_x, start_y, end_x, end_y, output ready);
endinterface

interface dda_out_if #(
  parameter int COORD_BITS = 11
);
  logic                         valid;
  logic                         ready;
  logic signed [COORD_BITS-1:0] point_x;
  logic signed [COORD_BITS-1:0] point_y;
  logic                         last_point;

  modport source (output valid, point_x, point_y, last_point, input ready);
  modport sink   (input valid, point_x, point_y, last_point, output ready);
endinterface

FILE: hdl/dda_div.sv
// Shared restoring divider: one quotient bit per cycle for the step increments.
`include "assert_macros.svh"

module dda_div
  import dda_pkg::*;
#(
  parameter int COORD_BITS = 11,
  parameter int FRAC_BITS  = 16
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  dda_div_req_t          req_i,
  input  logic [COORD_BITS-1:0] dividend_i,
  input  logic [COORD_BITS-1:0] divisor_i,
  output dda_div_rsp_t          rsp_o,
  output logic [FRAC_BITS:0]    quotient_o
);

  localparam int RemW = COORD_BITS + 1;
  localparam int CntW = $clog2(FRAC_BITS + 1);

  logic                  busy_q;
  logic                  done_q;
  logic [CntW-1:0]       cnt_q;
  logic [RemW-1:0]       rem_q;
  logic [COORD_BITS-1:0] divisor_q;
  logic [FRAC_BITS:0]    quo_q;

  logic [RemW-1:0]       div_ext;
  logic [RemW-1:0]       diff;
  logic                  ge;
  logic [RemW-1:0]       rem_kept;

  // Trial subtract: the one arithmetic unit shared by both divisions
  assign div_ext  = {1'b0, divisor_q};
  assign ge       = rem_q >= div_ext;
  assign diff     = rem_q - div_ext;
  assign rem_kept = ge ? diff : rem_q;

  // Load operands, then shift in one quotient bit per cycle
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else if (req_i.start) begin
      busy_q <= 1'b1;
      done_q <= 1'b0;
      cnt_q  <= CntW'(FRAC_BITS);
    end else if (busy_q) begin
      if (cnt_q == '0) begin
        busy_q <= 1'b0;
        done_q <= 1'b1;
      end else begin
        cnt_q <= cnt_q - 1'b1;
      end
    end else begin
      done_q <= 1'b0;
    end
  end

  // Datapath registers
  always_ff @(posedge clk_i) begin
    if (req_i.start) begin
      rem_q     <= {1'b0, dividend_i};
      divisor_q <= divisor_i;
      quo_q     <= '0;
    end else if (busy_q) begin
      rem_q <= {rem_kept[RemW-2:0], 1'b0};
      quo_q <= {quo_q[FRAC_BITS-1:0], ge};
    end
  end

  assign rsp_o.busy = busy_q;
  assign rsp_o.done = done_q;
  assign quotient_o = quo_q;

  `ASSERT_AT(a_done_single, clk_i, rst_ni, done_q |=> !done_q)
  `ASSERT_NEVER(a_done_while_busy, clk_i, rst_ni, done_q && busy_q)
  `ASSERT_AT(a_rem_bound, clk_i, rst_ni, busy_q |-> (rem_q < {divisor_q, 1'b0}))

endmodule

FILE: hdl/dda_line_point_generator_top.sv
// Top level of the DDA line point generator: sequencer, accumulators, output register.
//
// Usage:
//   cmd_i carries requests. A start request (command 0) holds both endpoints
//   and returns the start point at once; the block then works out the x and
//   y step increments on one shared divider and takes no request meanwhile.
//   Each advance request (command 1) returns the next point until the line's
//   n+1 points (n = max(|dx|,|dy|)) have been given; the last one carries
//   last_point. An advance with no line in progress returns nothing.
//   A start request drops any line in progress.
// Timing:
//   A point enters the output register on the edge that accepts its request.
//   An advance keeps the sequencer idle. A start on a line of nonzero length keeps
//   cmd_i.ready low while the shared divider runs two divisions of FRAC_BITS+1
//   quotient bits, x then y, each followed by a hand-over of the result; a
//   start on a line of zero length launches no division.
// Stalls and reset:
//   pt_o holds its point while pt_o.ready is low; a request is taken only
//   when the output register is empty or being emptied in the same cycle.
//   Reset empties the output register and ends any line in progress.
`include "assert_macros.svh"

module dda_line_point_generator_top
  import dda_pkg::*;
#(
  parameter int COORD_BITS = 11,
  parameter int FRAC_BITS  = 16
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  dda_in_if.sink     cmd_i,
  dda_out_if.source  pt_o
);

  localparam int AccW = COORD_BITS + FRAC_BITS + 1;
  localparam int IncW = FRAC_BITS + 2;
  localparam int DW   = COORD_BITS + 1;

  typedef enum logic [1:0] {
    S_IDLE,
    S_DIV_X,
    S_DIV_Y
  } state_e;

  state_e state_q, state_d;

  logic signed [AccW-1:0] acc_x_q, acc_x_d;
  logic signed [AccW-1:0] acc_y_q, acc_y_d;
  logic signed [IncW-1:0] inc_x_q, inc_x_d;
  logic signed [IncW-1:0] inc_y_q, inc_y_d;
  logic [COORD_BITS-1:0]  points_left_q, points_left_d;
  logic                   line_active_q, line_active_d;
  logic [COORD_BITS-1:0]  mag_y_q, mag_y_d;
  logic                   neg_x_q, neg_x_d;
  logic                   neg_y_q, neg_y_d;

  logic                   out_valid_q, out_valid_d;
  logic [COORD_BITS-1:0]  out_x_q, out_x_d;
  logic [COORD_BITS-1:0]  out_y_q, out_y_d;
  logic                   out_last_q, out_last_d;

  logic                   accept;
  logic                   is_adv;
  logic [DW-1:0]          dx;
  logic [DW-1:0]          dy;
  logic [DW-1:0]          dx_neg;
  logic [DW-1:0]          dy_neg;
  logic [COORD_BITS-1:0]  ax;
  logic [COORD_BITS-1:0]  ay;
  logic [COORD_BITS-1:0]  n_in;

  dda_div_req_t           div_req;
  dda_div_rsp_t           div_rsp;
  logic [COORD_BITS-1:0]  div_dividend;
  logic [COORD_BITS-1:0]  div_divisor;
  logic [FRAC_BITS:0]     div_quo;
  logic [IncW-1:0]        quo_ext;

  // Round a fixed-point accumulator toward zero and keep the coordinate bits
  function automatic logic [COORD_BITS-1:0] coord_of(input logic [AccW-1:0] a);
    logic [DW-1:0] fl;
    logic          up;
    fl = a[AccW-1:FRAC_BITS];
    up = a[AccW-1] & (|a[FRAC_BITS-1:0]);
    coord_of = COORD_BITS'(fl + DW'(up));
  endfunction

  // Request handshake: take a request only when idle and the output slot frees
  assign cmd_i.ready = (state_q == S_IDLE) && (!out_valid_q || pt_o.ready);
  assign accept      = cmd_i.valid && cmd_i.ready;
  assign is_adv      = cmd_e'(cmd_i.command) == CMD_ADVANCE;

  // Line extent from the endpoints
  assign dx     = {cmd_i.end_x[COORD_BITS-1], cmd_i.end_x}
                - {cmd_i.start_x[COORD_BITS-1], cmd_i.start_x};
  assign dy     = {cmd_i.end_y[COORD_BITS-1], cmd_i.end_y}
                - {cmd_i.start_y[COORD_BITS-1], cmd_i.start_y};
  assign dx_neg = -dx;
  assign dy_neg = -dy;
  assign ax     = dx[DW-1] ? dx_neg[COORD_BITS-1:0] : dx[COORD_BITS-1:0];
  assign ay     = dy[DW-1] ? dy_neg[COORD_BITS-1:0] : dy[COORD_BITS-1:0];
  assign n_in   = (ax > ay) ? ax : ay;

  assign quo_ext = {1'b0, div_quo};

  // Sequencer and accumulator update
  always_comb begin
    state_d       = state_q;
    acc_x_d       = acc_x_q;
    acc_y_d       = acc_y_q;
    inc_x_d       = inc_x_q;
    inc_y_d       = inc_y_q;
    points_left_d = points_left_q;
    line_active_d = line_active_q;
    mag_y_d       = mag_y_q;
    neg_x_d       = neg_x_q;
    neg_y_d       = neg_y_q;
    out_valid_d   = out_valid_q && !pt_o.ready;
    out_x_d       = out_x_q;
    out_y_d       = out_y_q;
    out_last_d    = out_last_q;
    div_req.start = 1'b0;
    div_dividend  = ax;
    div_divisor   = n_in;

    unique case (state_q)
      S_IDLE: begin
        if (accept && !is_adv) begin
          // Start: load the start point and, for a line of nonzero length, launch the x division
          acc_x_d       = {cmd_i.start_x[COORD_BITS-1], cmd_i.start_x, {FRAC_BITS{1'b0}}};
          acc_y_d       = {cmd_i.start_y[COORD_BITS-1], cmd_i.start_y, {FRAC_BITS{1'b0}}};
          inc_x_d       = '0;
          inc_y_d       = '0;
          points_left_d = n_in;
          line_active_d = n_in != '0;
          mag_y_d       = ay;
          neg_x_d       = dx[DW-1];
          neg_y_d       = dy[DW-1];
          out_valid_d   = 1'b1;
          out_x_d       = coord_of(acc_x_d);
          out_y_d       = coord_of(acc_y_d);
          out_last_d    = n_in == '0;
          if (n_in != '0) begin
            div_req.start = 1'b1;
            state_d       = S_DIV_X;
          end
        end else if (accept && line_active_q) begin
          // Advance: step both accumulators by one increment
          acc_x_d       = acc_x_q + {{(AccW-IncW){inc_x_q[IncW-1]}}, inc_x_q};
          acc_y_d       = acc_y_q + {{(AccW-IncW){inc_y_q[IncW-1]}}, inc_y_q};
          points_left_d = points_left_q - 1'b1;
          line_active_d = points_left_d != '0;
          out_valid_d   = 1'b1;
          out_x_d       = coord_of(acc_x_d);
          out_y_d       = coord_of(acc_y_d);
          out_last_d    = points_left_d == '0;
        end
      end
      S_DIV_X: begin
        // Take the x increment, reuse the divider for y
        div_dividend = mag_y_q;
        div_divisor  = points_left_q;
        if (div_rsp.done) begin
          inc_x_d       = neg_x_q ? -quo_ext : quo_ext;
          div_req.start = 1'b1;
          state_d       = S_DIV_Y;
        end
      end
      S_DIV_Y: begin
        if (div_rsp.done) begin
          inc_y_d = neg_y_q ? -quo_ext : quo_ext;
          state_d = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  // Control state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q       <= S_IDLE;
      points_left_q <= '0;
      line_active_q <= 1'b0;
      out_valid_q   <= 1'b0;
    end else begin
      state_q       <= state_d;
      points_left_q <= points_left_d;
      line_active_q <= line_active_d;
      out_valid_q   <= out_valid_d;
    end
  end

  // Payload state
  always_ff @(posedge clk_i) begin
    acc_x_q    <= acc_x_d;
    acc_y_q    <= acc_y_d;
    inc_x_q    <= inc_x_d;
    inc_y_q    <= inc_y_d;
    mag_y_q    <= mag_y_d;
    neg_x_q    <= neg_x_d;
    neg_y_q    <= neg_y_d;
    out_x_q    <= out_x_d;
    out_y_q    <= out_y_d;
    out_last_q <= out_last_d;
  end

  dda_div #(
    .COORD_BITS (COORD_BITS),
    .FRAC_BITS  (FRAC_BITS)
  ) u_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .req_i      (div_req),
    .dividend_i (div_dividend),
    .divisor_i  (div_divisor),
    .rsp_o      (div_rsp),
    .quotient_o (div_quo)
  );

  // Drive the point channel
  assign pt_o.valid      = out_valid_q;
  assign pt_o.point_x    = out_x_q;
  assign pt_o.point_y    = out_y_q;
  assign pt_o.last_point = out_last_q;

  `ASSERT_AT(a_active_matches_count, clk_i, rst_ni, line_active_q == (points_left_q != '0))
  `ASSERT_AT(a_done_in_div_state, clk_i, rst_ni,
             div_rsp.done |-> (state_q == S_DIV_X || state_q == S_DIV_Y))
  `ASSERT_NEVER(a_start_while_busy, clk_i, rst_ni, div_req.start && div_rsp.busy)
  `ASSERT_AT(a_y_done_to_idle, clk_i, rst_ni,
             (state_q == S_DIV_Y && div_rsp.done) |=> state_q == S_IDLE)

endmodule

FILE: dv/testbench.sv
// Testbench of the DDA line point generator: random and directed line requests checked point by point.
`timescale 1ns / 100ps

module testbench;
  import dda_pkg::*;

  localparam int COORD_BITS  = 11;
  localparam int FRAC_BITS   = 16;
  localparam int COORD_MIN   = -(1 << (COORD_BITS - 1));
  localparam int COORD_MAX   = (1 << (COORD_BITS - 1)) - 1;
  localparam int DIV_CYCLES  = 2 * (FRAC_BITS + 2);
  localparam int TARGET_REQS = 1200;

  typedef logic signed [COORD_BITS-1:0] coord_t;

  typedef struct {
    cmd_e   command;
    coord_t sx;
    coord_t sy;
    coord_t ex;
    coord_t ey;
  } line_req_t;

  typedef struct {
    coord_t x;
    coord_t y;
    logic   last;
  } point_t;

  logic clk_i;
  logic rst_ni;

  dda_in_if  #(.COORD_BITS(COORD_BITS)) cmd_if ();
  dda_out_if #(.COORD_BITS(COORD_BITS)) pt_if ();

  dda_line_point_generator_top #(
    .COORD_BITS(COORD_BITS),
    .FRAC_BITS (FRAC_BITS)
  ) dut (
    .clk_i (clk_i),
    .rst_ni(rst_ni),
    .cmd_i (cmd_if),
    .pt_o  (pt_if)
  );

  line_req_t pending_reqs[$];
  point_t    expected_points[$];

  int  mismatches;
  int  points_seen;
  int  plan_left;
  int  plan_reqs;
  int  send_gap;
  int  drain_gap;
  int  cyc;
  bit  req_taken;
  bit  hold_off;

  // Line state of the predictor
  longint pen_x;
  longint pen_y;
  longint step_x;
  longint step_y;
  int     steps_left;
  bit     drawing;

  // Clock
  initial clk_i = 1'b0;
  always #6 clk_i = ~clk_i;

  // Count a mismatch and print it
  task automatic flag_mismatch(input string what);
    mismatches++;
    $display("%0t ns: mismatch: %s", $time, what);
  endtask

  // Pick an idle stretch: mostly none, some short, a few long
  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 90) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  function automatic int abs_of(input int v);
    return v < 0 ? -v : v;
  endfunction

  function automatic int rand_coord();
    return int'($urandom_range(0, (1 << COORD_BITS) - 1)) + COORD_MIN;
  endfunction

  // Random coordinate within span of c, clamped to the coordinate range
  function automatic int near(input int c, input int span);
    int v;
    v = c + int'($urandom_range(0, 2 * span)) - span;
    if (v < COORD_MIN) v = COORD_MIN;
    if (v > COORD_MAX) v = COORD_MAX;
    return v;
  endfunction

  function automatic int line_len(input int sx, input int sy, input int ex, input int ey);
    int adx;
    int ady;
    adx = abs_of(ex - sx);
    ady = abs_of(ey - sy);
    return adx > ady ? adx : ady;
  endfunction

  // Queue an advance with junk endpoint fields
  task automatic queue_advance();
    line_req_t r;
    r.command = CMD_ADVANCE;
    r.sx = coord_t'($urandom_range(0, (1 << COORD_BITS) - 1));
    r.sy = coord_t'($urandom_range(0, (1 << COORD_BITS) - 1));
    r.ex = coord_t'($urandom_range(0, (1 << COORD_BITS) - 1));
    r.ey = coord_t'($urandom_range(0, (1 << COORD_BITS) - 1));
    pending_reqs.push_back(r);
    if (plan_left > 0) begin
      plan_left--;
      plan_reqs++;
    end
  endtask

  // Queue a start followed by a number of advances
  task automatic queue_line(input int sx, input int sy, input int ex, input int ey,
                            input int advances);
    line_req_t r;
    r.command = CMD_START;
    r.sx = sx[COORD_BITS-1:0];
    r.sy = sy[COORD_BITS-1:0];
    r.ex = ex[COORD_BITS-1:0];
    r.ey = ey[COORD_BITS-1:0];
    pending_reqs.push_back(r);
    plan_left = line_len(sx, sy, ex, ey);
    plan_reqs++;
    repeat (advances) queue_advance();
  endtask

  // Scaled difference divided by n, truncated toward zero
  function automatic longint step_size(input longint d, input longint n);
    longint q;
    q = ((d < 0 ? -d : d) <<< FRAC_BITS) / n;
    return d < 0 ? -q : q;
  endfunction

  // Accumulator truncated toward zero, cut to the coordinate width
  function automatic coord_t coord_from(input longint a);
    longint q;
    q = (a < 0 ? -a : a) >>> FRAC_BITS;
    if (a < 0) q = -q;
    return q[COORD_BITS-1:0];
  endfunction

  // Advance the predictor by one accepted request and queue its point, if it has one
  task automatic plot_request(input line_req_t r);
    longint dx;
    longint dy;
    longint n;
    point_t p;
    if (r.command == CMD_START) begin
      dx = longint'(r.ex) - longint'(r.sx);
      dy = longint'(r.ey) - longint'(r.sy);
      n = (dx < 0 ? -dx : dx) > (dy < 0 ? -dy : dy) ? (dx < 0 ? -dx : dx)
                                                    : (dy < 0 ? -dy : dy);
      pen_x = longint'(r.sx) * (longint'(1) << FRAC_BITS);
      pen_y = longint'(r.sy) * (longint'(1) << FRAC_BITS);
      if (n == 0) begin
        step_x = 0;
        step_y = 0;
      end else begin
        step_x = step_size(dx, n);
        step_y = step_size(dy, n);
      end
      steps_left = int'(n);
      drawing = n != 0;
    end else begin
      // drop an advance with no line in progress
      if (!drawing) return;
      pen_x += step_x;
      pen_y += step_y;
      steps_left--;
      if (steps_left == 0) drawing = 1'b0;
    end
    p.x = coord_from(pen_x);
    p.y = coord_from(pen_y);
    p.last = steps_left == 0;
    expected_points.push_back(p);
  endtask

  // Compare one delivered point with the oldest expected one
  task automatic check_point();
    point_t p;
    if (expected_points.size() == 0) begin
      flag_mismatch($sformatf("point (%0d,%0d) with none expected",
                              pt_if.point_x, pt_if.point_y));
      return;
    end
    p = expected_points.pop_front();
    if (pt_if.point_x !== p.x)
      flag_mismatch($sformatf("point_x %0d, expected %0d", pt_if.point_x, p.x));
    if (pt_if.point_y !== p.y)
      flag_mismatch($sformatf("point_y %0d, expected %0d", pt_if.point_y, p.y));
    if (pt_if.last_point !== p.last)
      flag_mismatch($sformatf("last_point %b, expected %b", pt_if.last_point, p.last));
  endtask

  // Sample both handshakes: check points first, then predict accepted requests
  always @(posedge clk_i) begin
    cyc <= cyc + 1;
    req_taken = 1'b0;
    if (rst_ni) begin
      if (pt_if.valid === 1'b1 && pt_if.ready === 1'b1) begin
        points_seen++;
        check_point();
      end
      if (cmd_if.valid === 1'b1 && cmd_if.ready === 1'b1) begin
        req_taken = 1'b1;
        plot_request('{cmd_e'(cmd_if.command), cmd_if.start_x, cmd_if.start_y,
                       cmd_if.end_x, cmd_if.end_y});
      end
    end
  end

  // Request driver: hold until taken, then idle or present the next request
  always @(negedge clk_i) begin
    line_req_t r;
    if (!rst_ni) begin
      cmd_if.valid <= 1'b0;
    end else if (cmd_if.valid && !req_taken) begin
      // hold the request
    end else if (send_gap > 0) begin
      send_gap <= send_gap - 1;
      cmd_if.valid <= 1'b0;
    end else if (pending_reqs.size() > 0) begin
      r = pending_reqs.pop_front();
      cmd_if.valid   <= 1'b1;
      cmd_if.command <= r.command;
      cmd_if.start_x <= r.sx;
      cmd_if.start_y <= r.sy;
      cmd_if.end_x   <= r.ex;
      cmd_if.end_y   <= r.ey;
      send_gap <= (cyc[9:8] == 2'd1) ? 0 : pick_gap();
    end else begin
      cmd_if.valid <= 1'b0;
    end
  end

  // Point receiver: stall at random, or hold off on request
  always @(negedge clk_i) begin
    if (!rst_ni) begin
      pt_if.ready <= 1'b0;
    end else if (hold_off) begin
      pt_if.ready <= 1'b0;
    end else if (drain_gap > 0) begin
      drain_gap <= drain_gap - 1;
      pt_if.ready <= 1'b0;
    end else begin
      pt_if.ready <= 1'b1;
      if (cyc[9:8] != 2'd2 && $urandom_range(0, 3) == 0) drain_gap <= pick_gap();
    end
  end

  // Long hold-offs so the output register fills and requests back up
  initial begin
    hold_off = 1'b0;
    for (int k = 1; k <= 2; k++) begin
      while (points_seen < k * 400) @(negedge clk_i);
      hold_off <= 1'b1;
      repeat (300) @(negedge clk_i);
      hold_off <= 1'b0;
    end
  end

  // Overall time limit
  initial begin
    #12_000_000;
    $display("CHECKS FAILED");
    $finish;
  end

  // Reset, stimulus and end of run
  initial begin
    int pick;
    int sx;
    int sy;
    int ex;
    int ey;
    int len;
    int span;

    rst_ni = 1'b0;
    cmd_if.valid = 1'b0;
    cmd_if.command = CMD_START;
    cmd_if.start_x = '0;
    cmd_if.start_y = '0;
    cmd_if.end_x = '0;
    cmd_if.end_y = '0;
    pt_if.ready = 1'b0;
    mismatches = 0;
    points_seen = 0;
    plan_left = 0;
    plan_reqs = 0;
    send_gap = 0;
    drain_gap = 0;
    cyc = 0;
    req_taken = 1'b0;
    pen_x = 0;
    pen_y = 0;
    step_x = 0;
    step_y = 0;
    steps_left = 0;
    drawing = 1'b0;

    // Directed: advance after reset, zero-length lines, extreme endpoints,
    // restart during a line, full short lines, one with an ignored trailing advance
    queue_advance();
    queue_line(0, 0, 0, 0, 1);
    queue_line(COORD_MIN, COORD_MAX, COORD_MIN, COORD_MAX, 0);
    queue_line(COORD_MIN, COORD_MIN, COORD_MAX, COORD_MAX, 3);
    queue_line(COORD_MAX, COORD_MIN, COORD_MIN, COORD_MAX, 2);
    queue_line(COORD_MAX, COORD_MAX, COORD_MIN, COORD_MIN, 1);
    queue_line(4, 0, -2, 0, 7);
    queue_line(-3, 4, -1, 0, 4);

    // Random: mostly complete lines, some cut short, some stray advances
    while (plan_reqs < TARGET_REQS) begin
      pick = $urandom_range(0, 99);
      sx = rand_coord();
      sy = rand_coord();
      if (pick < 55) begin
        span = $urandom_range(1, 12);
        ex = near(sx, span);
        ey = near(sy, span);
        len = line_len(sx, sy, ex, ey);
        queue_line(sx, sy, ex, ey,
                   len + (($urandom_range(0, 3) == 0) ? $urandom_range(1, 2) : 0));
      end else if (pick < 74) begin
        span = (pick < 72) ? $urandom_range(13, 100) : $urandom_range(101, 400);
        ex = near(sx, span);
        ey = near(sy, span);
        queue_line(sx, sy, ex, ey, line_len(sx, sy, ex, ey));
      end else if (pick < 84) begin
        queue_line(sx, sy, rand_coord(), rand_coord(), $urandom_range(0, 8));
      end else if (pick < 90) begin
        queue_line(sx, sy, sx, sy, $urandom_range(0, 1));
      end else if (pick < 95) begin
        span = $urandom_range(2, 30);
        ex = near(sx, span);
        ey = near(sy, span);
        len = line_len(sx, sy, ex, ey);
        queue_line(sx, sy, ex, ey, (len > 0) ? $urandom_range(0, len - 1) : 0);
      end else begin
        repeat ($urandom_range(1, 3)) queue_advance();
      end
    end

    repeat (7) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    // Drain: every request taken, every point delivered, then settle
    while (pending_reqs.size() != 0 || cmd_if.valid) @(posedge clk_i);
    while (expected_points.size() != 0) @(posedge clk_i);
    repeat (DIV_CYCLES + 10) @(posedge clk_i);

    if (mismatches == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule

FILE: files.f
+incdir+hdl
hdl/dda_pkg.sv
hdl/dda_if.sv
hdl/dda_div.sv
hdl/dda_line_point_generator_top.sv
dv/testbench.sv
